[hw/rtl/iif_pkg.sv]
package iif_pkg;

    localparam int FIFO_DEPTH_DEF = 64;
    localparam int PADDR_W        = 2;
    localparam int PDATA_W        = 32;

    localparam logic [PADDR_W-1:0] REG_FIFO_PORT = '0;

    localparam logic [7:0] PORT_RESET = 8'h04;
    localparam logic [7:0] TAG_SERIAL = 8'h01;
    localparam logic [7:0] TAG_KEY    = 8'h02;
    localparam logic [7:0] KEY_BREAK  = 8'hF0;
    localparam logic [2:0] IRQ_LINE   = 3'd0;

    localparam logic [2:0] CMD_SERIAL  = 3'd0;
    localparam logic [2:0] CMD_PRESS   = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_POLL    = 3'd4;

    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_SERIAL  = 3'd1;
    localparam logic [2:0] OP_PRESS   = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;
    localparam logic [2:0] OP_POLL    = 3'd5;

    localparam logic [1:0] IRQ_NONE     = 2'd0;
    localparam logic [1:0] IRQ_PENDING  = 2'd1;
    localparam logic [1:0] IRQ_SIGNALED = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_op;

    function automatic logic [2:0] grp_len(input logic [2:0] kind);
        grp_len = (kind == OP_RELEASE) ? 3'd4 : 3'd2;
    endfunction

    function automatic logic [7:0] grp_byte(input logic [2:0] kind, input logic [1:0] idx,
                                            input logic [7:0] data);
        logic [7:0] b;
        b = data;
        case (idx)
            2'd0: begin
                b = (kind == OP_SERIAL) ? TAG_SERIAL : TAG_KEY;
            end
            2'd1: begin
                b = (kind == OP_RELEASE) ? KEY_BREAK : data;
            end
            2'd2: begin
                b = TAG_KEY;
            end
            default: begin
                b = data;
            end
        endcase
        grp_byte = b;
    endfunction

endpackage

[hw/rtl/iif_if.sv]
interface iif_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] io_port;

    modport source (output valid, cmd, data_byte, io_port, input ready);
    modport sink (input valid, cmd, data_byte, io_port, output ready);
endinterface

interface iif_out_if #(
    parameter int LEVEL_W = 7
);
    logic               valid;
    logic               ready;
    logic [7:0]         read_data;
    logic               read_handled;
    logic               irq_taken;
    logic [2:0]         irq_line;
    logic [LEVEL_W-1:0] fifo_level;
    logic               dropped;

    modport source (output valid, read_data, read_handled, irq_taken, irq_line, fifo_level,
                    dropped, input ready);
    modport sink (input valid, read_data, read_handled, irq_taken, irq_line, fifo_level,
                  dropped, output ready);
endinterface

[hw/rtl/interrupting_input_fifo.sv]
// Byte FIFO that merges serial bytes and keyboard scan codes into tagged groups for a CPU.
// Requests arrive on i_in (cmd, data_byte, io_port) with a valid/ready handshake; every request
// gives exactly one response on o_out with a valid/ready handshake. The o_out interface must be
// built with LEVEL_W equal to $clog2(FIFO_DEPTH + 1).
// The APB port holds one register, the port address at which reads pop the FIFO.
// A request passes through a two-entry queue into the execution unit, and the response is held
// in an output register. Polls, misses, dropped groups and reads of an empty FIFO are answered
// straight from the idle state; a read that pops a byte first reads the byte store, and a serial
// byte, key press or key release first writes each byte of its group.
// The execution unit takes no new request until it is back in the idle state and the output
// register is free; it writes one byte at a time, since the byte store has a single write and a
// single read port.
// Reset empties the FIFO, clears the interrupt state and sets the port address to 4; the byte
// store itself is not cleared.
// When the receiver stalls, the response stays in the output register, the queue fills with
// up to two more requests and then i_in.ready goes low.
module interrupting_input_fifo #(
    parameter int FIFO_DEPTH = iif_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iif_pkg::PADDR_W-1:0] paddr,
    input  logic [iif_pkg::PDATA_W-1:0] pwdata,
    output logic [iif_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    iif_in_if.sink                      i_in,
    iif_out_if.source                   o_out
);
    import iif_pkg::*;

    logic push_valid;
    t_op  push_op;
    logic push_ready;
    logic op_valid;
    t_op  op;
    logic op_ready;

    iif_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_op    (push_op),
        .i_push_ready (push_ready)
    );

    iif_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_op    (push_op),
        .o_push_ready (push_ready),
        .o_pop_valid  (op_valid),
        .o_pop_op     (op),
        .i_pop_ready  (op_ready)
    );

    iif_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_ready (op_ready),
        .o_out      (o_out)
    );
endmodule

[hw/rtl/iif_ram.sv]
module iif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/iif_front.sv]
module iif_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iif_pkg::PADDR_W-1:0] paddr,
    input  logic [iif_pkg::PDATA_W-1:0] pwdata,
    output logic [iif_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    iif_in_if.sink                      i_in,
    output logic                        o_push_valid,
    output iif_pkg::t_op                o_push_op,
    input  logic                        i_push_ready
);
    import iif_pkg::*;

    logic [7:0] r_fifo_port;
    logic [7:0] n_fifo_port;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_FIFO_PORT);

    always_comb begin
        n_fifo_port = r_fifo_port;
        if (cfg_wr) begin
            n_fifo_port = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_port <= PORT_RESET;
        end else begin
            r_fifo_port <= n_fifo_port;
        end
    end

    assign prdata = (paddr == REG_FIFO_PORT) ? {{(PDATA_W-8){1'b0}}, r_fifo_port} : '0;

    // A read at any other port changes nothing, so it travels as a no-op.
    always_comb begin
        o_push_op.data = i_in.data_byte;
        case (i_in.cmd)
            CMD_SERIAL: begin
                o_push_op.kind = OP_SERIAL;
            end
            CMD_PRESS: begin
                o_push_op.kind = OP_PRESS;
            end
            CMD_RELEASE: begin
                o_push_op.kind = OP_RELEASE;
            end
            CMD_READ: begin
                o_push_op.kind = (i_in.io_port == r_fifo_port) ? OP_READ : OP_NOP;
            end
            CMD_POLL: begin
                o_push_op.kind = OP_POLL;
            end
            default: begin
                o_push_op.kind = OP_NOP;
            end
        endcase
    end

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;
endmodule

[hw/rtl/iif_queue.sv]
module iif_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    input  iif_pkg::t_op i_push_op,
    output logic         o_push_ready,
    output logic         o_pop_valid,
    output iif_pkg::t_op o_pop_op,
    input  logic         i_pop_ready
);
    import iif_pkg::*;

    t_op        r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_op     = r_buf[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr  = push ? ~r_wr : r_wr;
        n_rd  = pop ? ~r_rd : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= i_push_op;
        end
    end
endmodule

[hw/rtl/iif_back.sv]
module iif_back #(
    parameter int FIFO_DEPTH = iif_pkg::FIFO_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_valid,
    input  iif_pkg::t_op i_op,
    output logic         o_op_ready,
    iif_out_if.source    o_out
);
    import iif_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_op           r_op;
    t_op           n_op;
    logic [1:0]    r_idx;
    logic [1:0]    n_idx;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [1:0]    r_irq;
    logic [1:0]    n_irq;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [7:0]    r_read_data;
    logic [7:0]    n_read_data;
    logic          r_handled;
    logic          n_handled;
    logic          r_taken;
    logic          n_taken;
    logic [CW-1:0] r_level;
    logic [CW-1:0] n_level;
    logic          r_dropped;
    logic          n_dropped;

    logic          out_free;
    logic          take;
    logic          res_valid;
    logic [7:0]    res_data;
    logic          res_handled;
    logic          res_taken;
    logic          res_dropped;
    logic [CW-1:0] res_level;
    logic [2:0]    len;
    logic [CW:0]   fill_sum;
    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        next_ptr = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free   = !r_out_valid || o_out.ready;
    assign o_op_ready = (r_state == ST_IDLE) && out_free;
    assign take       = i_op_valid && o_op_ready;
    assign len        = grp_len(i_op.kind);
    assign fill_sum   = {1'b0, r_count} + (CW+1)'(len);
    assign ram_wdata  = grp_byte(r_op.kind, r_idx, r_op.data);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_irq       = r_irq;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        res_valid   = 1'b0;
        res_data    = 8'd0;
        res_handled = 1'b0;
        res_taken   = 1'b0;
        res_dropped = 1'b0;
        res_level   = r_count;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    case (i_op.kind)
                        OP_SERIAL, OP_PRESS, OP_RELEASE: begin
                            if (fill_sum > (CW+1)'(FIFO_DEPTH)) begin
                                res_valid   = 1'b1;
                                res_dropped = 1'b1;
                            end else begin
                                n_op    = i_op;
                                n_idx   = 2'd0;
                                n_state = ST_PUSH;
                            end
                        end
                        OP_READ: begin
                            if (r_count != '0) begin
                                ram_re   = 1'b1;
                                n_rd_ptr = next_ptr(r_rd_ptr);
                                n_count  = r_count - 1'b1;
                                n_irq    = (r_count != CW'(1)) ? IRQ_PENDING : IRQ_NONE;
                                n_state  = ST_READ;
                            end else begin
                                n_irq     = IRQ_NONE;
                                res_valid = 1'b1;
                            end
                        end
                        OP_POLL: begin
                            res_valid = 1'b1;
                            if (r_irq == IRQ_PENDING) begin
                                n_irq     = IRQ_SIGNALED;
                                res_taken = 1'b1;
                            end
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_PUSH: begin
                ram_we   = 1'b1;
                n_wr_ptr = next_ptr(r_wr_ptr);
                n_idx    = r_idx + 2'd1;
                if (r_idx == 2'(grp_len(r_op.kind) - 3'd1)) begin
                    n_count   = r_count + CW'(grp_len(r_op.kind));
                    res_valid = 1'b1;
                    res_level = r_count + CW'(grp_len(r_op.kind));
                    if (r_irq == IRQ_NONE) begin
                        n_irq = IRQ_PENDING;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                res_valid   = 1'b1;
                res_data    = ram_rdata;
                res_handled = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_read_data = r_read_data;
        n_handled   = r_handled;
        n_taken     = r_taken;
        n_level     = r_level;
        n_dropped   = r_dropped;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_read_data = res_data;
            n_handled   = res_handled;
            n_taken     = res_taken;
            n_level     = res_level;
            n_dropped   = res_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_irq       <= IRQ_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_irq       <= n_irq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_read_data <= n_read_data;
        r_handled   <= n_handled;
        r_taken     <= n_taken;
        r_level     <= n_level;
        r_dropped   <= n_dropped;
    end

    iif_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_read_data;
    assign o_out.read_handled = r_handled;
    assign o_out.irq_taken    = r_taken;
    assign o_out.irq_line     = IRQ_LINE;
    assign o_out.fifo_level   = r_level;
    assign o_out.dropped      = r_dropped;
endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

    import iif_pkg::*;

    localparam int          DEPTH       = FIFO_DEPTH_DEF;
    localparam int          LEVEL_W     = $clog2(FIFO_DEPTH_DEF + 1);
    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [2:0]  CMD_LAST    = 3'd7;

    typedef struct packed {
        logic [7:0]         read_data;
        logic               read_handled;
        logic               irq_taken;
        logic [2:0]         irq_line;
        logic [LEVEL_W-1:0] fifo_level;
        logic               dropped;
    } t_fifo_resp;

    class fifo_scoreboard;
        logic [7:0] held_bytes[$];
        logic [1:0] irq_state;
        logic [7:0] pop_port;
        t_fifo_resp due_responses[$];
        int         errors;

        function new();
            irq_state = IRQ_NONE;
            pop_port  = PORT_RESET;
            errors    = 0;
        endfunction

        function void set_port(logic [7:0] port);
            pop_port = port;
        endfunction

        function int pending();
            return due_responses.size();
        endfunction

        function void note_request(logic [2:0] cmd, logic [7:0] data, logic [7:0] port);
            t_fifo_resp r;
            logic [7:0] grp[$];
            r          = '0;
            r.irq_line = IRQ_LINE;
            case (cmd)
                CMD_SERIAL: begin
                    grp = {grp, TAG_SERIAL, data};
                end
                CMD_PRESS: begin
                    grp = {grp, TAG_KEY, data};
                end
                CMD_RELEASE: begin
                    grp = {grp, TAG_KEY, KEY_BREAK, TAG_KEY, data};
                end
                CMD_READ: begin
                    if (port == pop_port) begin
                        if (held_bytes.size() > 0) begin
                            r.read_data    = held_bytes.pop_front();
                            r.read_handled = 1'b1;
                        end
                        irq_state = (held_bytes.size() > 0) ? IRQ_PENDING : IRQ_NONE;
                    end
                end
                CMD_POLL: begin
                    if (irq_state == IRQ_PENDING) begin
                        irq_state   = IRQ_SIGNALED;
                        r.irq_taken = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (grp.size() > 0) begin
                if (held_bytes.size() + grp.size() > DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    held_bytes = {held_bytes, grp};
                    if (irq_state == IRQ_NONE) begin
                        irq_state = IRQ_PENDING;
                    end
                end
            end
            r.fifo_level  = LEVEL_W'(held_bytes.size());
            due_responses = {due_responses, r};
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_fifo_resp got);
            t_fifo_resp want;
            if (due_responses.size() == 0) begin
                $display("%0t: response with none expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = due_responses.pop_front();
            compare("read_data", want.read_data, got.read_data);
            compare("read_handled", 8'(want.read_handled), 8'(got.read_handled));
            compare("irq_taken", 8'(want.irq_taken), 8'(got.irq_taken));
            compare("irq_line", 8'(want.irq_line), 8'(got.irq_line));
            compare("fifo_level", 8'(want.fifo_level), 8'(got.fifo_level));
            compare("dropped", 8'(want.dropped), 8'(got.dropped));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    iif_in_if                         req_if ();
    iif_out_if #(.LEVEL_W(LEVEL_W))   resp_if ();

    fifo_scoreboard sb;
    bit             send_idle;
    bit             recv_idle;
    int             stall_left;
    int             cycle_count;

    interrupting_input_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (req_if),
        .o_out   (resp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_fifo_resp got;
        if (i_rst_n && resp_if.valid === 1'b1 && resp_if.ready) begin
            got.read_data    = resp_if.read_data;
            got.read_handled = resp_if.read_handled;
            got.irq_taken    = resp_if.irq_taken;
            got.irq_line     = resp_if.irq_line;
            got.fifo_level   = resp_if.fifo_level;
            got.dropped      = resp_if.dropped;
            sb.check_response(got);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            resp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            resp_if.ready <= 1'b0;
        end else if (recv_idle && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 5);
            resp_if.ready <= 1'b0;
        end else begin
            resp_if.ready <= 1'b1;
        end
    end

    task automatic send_request(logic [2:0] cmd, logic [7:0] data, logic [7:0] port);
        int gap;
        gap = (send_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.cmd       <= cmd;
        req_if.data_byte <= data;
        req_if.io_port   <= port;
        forever begin
            @(posedge i_clk);
            if (req_if.ready) break;
        end
        sb.note_request(cmd, data, port);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_fifo_port(logic [7:0] port);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_FIFO_PORT;
        pwdata  <= {{(PDATA_W - 8){1'b0}}, port};
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_port(port);
    endtask

    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Filling stretches lean on pushes so that groups get dropped at the top;
    // draining stretches lean on reads so that the empty case is reached.
    task automatic random_requests(int count, bit quiet);
        int         left;
        int         r;
        bit         filling;
        logic [2:0] cmd;
        logic [7:0] port;
        left    = 0;
        filling = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (left == 0) begin
                filling   = ~filling;
                left      = $urandom_range(10, 40);
                send_idle = !quiet && $urandom_range(0, 3) != 0;
                recv_idle = !quiet && $urandom_range(0, 3) != 0;
            end
            left--;
            r    = $urandom_range(0, 99);
            port = sb.pop_port;
            if (filling) begin
                if (r < 30) cmd = CMD_SERIAL;
                else if (r < 50) cmd = CMD_PRESS;
                else if (r < 75) cmd = CMD_RELEASE;
                else if (r < 85) cmd = CMD_READ;
                else if (r < 93) cmd = CMD_POLL;
                else if (r < 97) begin
                    cmd  = CMD_READ;
                    port = 8'($urandom_range(0, 255));
                end else cmd = 3'($urandom_range(CMD_POLL + 1, CMD_LAST));
            end else begin
                if (r < 15) cmd = 3'($urandom_range(CMD_SERIAL, CMD_RELEASE));
                else if (r < 70) cmd = CMD_READ;
                else if (r < 85) cmd = CMD_POLL;
                else if (r < 93) begin
                    cmd  = CMD_READ;
                    port = 8'($urandom_range(0, 255));
                end else cmd = 3'($urandom_range(CMD_POLL + 1, CMD_LAST));
            end
            send_request(cmd, pick_data(), port);
        end
    endtask

    initial begin
        logic [7:0] ports[5];
        sb                = new();
        cycle_count       = 0;
        stall_left        = 0;
        send_idle         = 1'b0;
        recv_idle         = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_SERIAL;
        req_if.data_byte  = 8'h00;
        req_if.io_port    = 8'h00;
        resp_if.ready     = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(CMD_POLL, 8'h00, 8'h00);
        send_request(CMD_READ, 8'h00, PORT_RESET);
        send_request(CMD_SERIAL, 8'h00, 8'hFF);
        send_request(CMD_PRESS, 8'hFF, 8'h00);
        send_request(CMD_POLL, 8'h00, 8'h00);
        send_request(CMD_POLL, 8'h00, 8'h00);
        send_request(CMD_RELEASE, 8'hA5, 8'h00);
        send_request(CMD_SERIAL, 8'hFF, 8'h00);
        send_request(CMD_RELEASE, 8'h00, 8'h00);
        send_request(CMD_READ, 8'h00, PORT_RESET + 8'd1);
        send_request(CMD_READ, 8'hFF, 8'hFF);
        send_request(CMD_READ, 8'h00, PORT_RESET);
        send_request(CMD_READ, 8'h00, PORT_RESET);
        send_request(CMD_POLL, 8'h00, 8'h00);
        send_request(CMD_POLL + 3'd1, 8'hFF, PORT_RESET);
        send_request(CMD_POLL + 3'd2, 8'h5A, PORT_RESET);
        send_request(CMD_LAST, 8'hFF, 8'hFF);
        repeat (12) send_request(CMD_READ, 8'h00, PORT_RESET);
        send_request(CMD_POLL, 8'h00, 8'h00);
        send_request(CMD_READ, 8'h00, PORT_RESET);
        wait_drained();

        ports[0] = 8'h00;
        ports[1] = 8'hFF;
        ports[2] = 8'($urandom_range(1, 254));
        ports[3] = 8'($urandom_range(0, 255));
        ports[4] = PORT_RESET;
        foreach (ports[p]) begin
            write_fifo_port(ports[p]);
            random_requests(53, p == 4);
            wait_drained();
            random_requests(53, p == 4);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/iif_pkg.sv
hw/rtl/iif_if.sv
hw/rtl/iif_ram.sv
hw/rtl/iif_front.sv
hw/rtl/iif_queue.sv
hw/rtl/iif_back.sv
hw/rtl/interrupting_input_fifo.sv
verif/tb.sv
